// ===== hdl/grk_pkg.sv =====
// Shared types, constants and fixed-point helpers for the GR potential kick block.
// Depends on nothing; used by every module under hdl.
`default_nettype none

package grk_pkg;

  // Fixed formats of the ports and of the internal magnitudes.
  localparam int WORD_BITS = 48;
  localparam int FRAC_BITS = 32;
  localparam int MASS_BITS = 40;
  localparam int COEF_BITS = 48;
  localparam int TIME_BITS = 32;
  localparam int MAG_BITS  = 64;
  localparam int PROD_BITS = 2 * MAG_BITS;
  localparam int R2_BITS   = 2 * WORD_BITS;
  localparam int DIV_STEPS = PROD_BITS;

  // Command codes and configuration register indexes.
  localparam logic CMD_LOAD      = 1'b0;
  localparam logic CMD_KICK      = 1'b1;
  localparam logic REG_GR_COEF   = 1'b0;
  localparam logic REG_KICK_TIME = 1'b1;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [MAG_BITS-1:0]  mag_t;
  typedef logic [PROD_BITS-1:0] prod_t;

  // Sequencer states: idle, separation, one per kind of operation of the shared units, and two emit states.
  typedef enum logic [3:0] {
    S_IDLE, S_DIFF, S_R2, S_COEF, S_P1, S_DEN, S_PREFAC, S_PDT,
    S_KICK, S_RMUL, S_RDIV, S_EMIT_BODY, S_EMIT_SRC
  } state_t;

  // Sign-magnitude value with a saturation flag.
  typedef struct packed {
    logic neg;
    mag_t mag;
    logic flag;
  } sm_t;

  // Encoded two's complement word with a clamp flag.
  typedef struct packed {
    word_t value;
    logic  flag;
  } enc_t;

  // Two's complement word to sign and magnitude.
  function automatic sm_t decode(input word_t v);
    sm_t r;
    r.neg  = v[WORD_BITS-1];
    r.mag  = {{(MAG_BITS-WORD_BITS){1'b0}}, (r.neg ? (~v + 1'b1) : v)};
    r.flag = 1'b0;
    return r;
  endfunction

  // Separation of two words, magnitude clamped to the positive word range.
  function automatic sm_t pos_diff(input word_t p, input word_t s);
    logic [WORD_BITS:0] d;
    logic [WORD_BITS:0] m;
    logic [WORD_BITS:0] lim;
    sm_t r;
    d     = {p[WORD_BITS-1], p} - {s[WORD_BITS-1], s};
    m     = d[WORD_BITS] ? (~d + 1'b1) : d;
    lim   = {2'b00, {(WORD_BITS-1){1'b1}}};
    r.neg = d[WORD_BITS];
    r.flag = (m > lim);
    r.mag = {{(MAG_BITS-WORD_BITS-1){1'b0}}, (r.flag ? lim : m)};
    return r;
  endfunction

  // Sign-magnitude sum; the magnitude saturates at all ones.
  function automatic sm_t sm_add(input logic an, input mag_t am, input logic bn,
                                 input mag_t bm);
    logic [MAG_BITS:0] s;
    sm_t r;
    s = {1'b0, am} + {1'b0, bm};
    r.flag = 1'b0;
    if (an == bn) begin
      r.neg  = an;
      r.flag = s[MAG_BITS];
      r.mag  = s[MAG_BITS] ? {MAG_BITS{1'b1}} : s[MAG_BITS-1:0];
    end else if (am >= bm) begin
      r.neg = an;
      r.mag = am - bm;
    end else begin
      r.neg = bn;
      r.mag = bm - am;
    end
    return r;
  endfunction

  // Sign and magnitude back to a word, clamped to the signed word range.
  function automatic enc_t encode(input logic neg, input mag_t mag);
    mag_t  lim;
    word_t m;
    enc_t  r;
    lim    = neg ? (mag_t'(1) << (WORD_BITS-1)) : ((mag_t'(1) << (WORD_BITS-1)) - 1'b1);
    r.flag = (mag > lim);
    m      = r.flag ? lim[WORD_BITS-1:0] : mag[WORD_BITS-1:0];
    r.value = neg ? (~m + 1'b1) : m;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/grk_mul.sv =====
// Iterative 64x64 multiplier built from four 32x32 partial products.
// Depends on grk_pkg for widths.
`default_nettype none

module grk_mul (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  grk_pkg::mag_t        a,
  input  grk_pkg::mag_t        b,
  output logic                 busy,
  output logic                 done,
  output grk_pkg::prod_t       prod
);

  localparam int HALF = grk_pkg::MAG_BITS / 2;

  grk_pkg::mag_t  a_q;
  grk_pkg::mag_t  b_q;
  logic [1:0]     cnt;
  logic [HALF-1:0] a_part;
  logic [HALF-1:0] b_part;
  grk_pkg::mag_t  pp;
  grk_pkg::prod_t pp_sh;

  // Partial product for this cycle, placed at its weight.
  always_comb begin
    a_part = cnt[1] ? a_q[grk_pkg::MAG_BITS-1:HALF] : a_q[HALF-1:0];
    b_part = cnt[0] ? b_q[grk_pkg::MAG_BITS-1:HALF] : b_q[HALF-1:0];
    pp     = a_part * b_part;
    pp_sh  = grk_pkg::prod_t'(pp) << {cnt[1] & cnt[0], cnt[1] ^ cnt[0], 5'b00000};
  end

  // Control: four accumulate steps, then a one-cycle done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 2'd0;
      end else if (busy) begin
        cnt <= cnt + 2'd1;
        if (cnt == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Operands and accumulator.
  always_ff @(posedge clk) begin
    if (start) begin
      a_q  <= a;
      b_q  <= b;
      prod <= '0;
    end else if (busy) begin
      prod <= prod + pp_sh;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/grk_div.sv =====
// Restoring divider, one quotient bit per cycle over the full product width.
// Depends on grk_pkg for widths.
`default_nettype none

module grk_div (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  grk_pkg::prod_t num,
  input  grk_pkg::prod_t den,
  output logic           done,
  output grk_pkg::prod_t quo
);

  localparam int CNT_BITS = $clog2(grk_pkg::DIV_STEPS);

  grk_pkg::prod_t rem;
  grk_pkg::prod_t den_q;
  logic           busy;
  logic [CNT_BITS-1:0] cnt;
  logic [grk_pkg::PROD_BITS:0] trial;
  logic           take;

  // Shift in the next numerator bit and try the subtraction.
  always_comb begin
    trial = {rem, quo[grk_pkg::PROD_BITS-1]};
    take  = (trial >= {1'b0, den_q});
  end

  // Control: one step per cycle, done pulse after the last.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_BITS'(grk_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient; the quotient register first holds the numerator.
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= num;
      den_q <= den;
    end else if (busy) begin
      rem <= take ? (trial[grk_pkg::PROD_BITS-1:0] - den_q) : trial[grk_pkg::PROD_BITS-1:0];
      quo <= {quo[grk_pkg::PROD_BITS-2:0], take};
    end
  end

endmodule

`default_nettype wire

// ===== hdl/gr_potential_velocity_kick_top.sv =====
// Load: accepted while idle; with last_body its source result is registered from the source emit
// state once the output is free. Kick: the separations are registered, then four divisions
// (prefactor, three reactions) and thirteen products run on the shared units; a zero separation or
// zero source mass skips the matching divisions. No new item is taken until the sequencer is idle.
// Reset (rst, synchronous): configuration and source state cleared to zero, sequencer idle.
// Depends on grk_pkg, grk_mul and grk_div.
`default_nettype none

module gr_potential_velocity_kick_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic                             cfg_index,
  input  logic [grk_pkg::COEF_BITS-1:0]    cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             command,
  input  logic signed [grk_pkg::WORD_BITS-1:0] pos_x,
  input  logic signed [grk_pkg::WORD_BITS-1:0] pos_y,
  input  logic signed [grk_pkg::WORD_BITS-1:0] pos_z,
  input  logic signed [grk_pkg::WORD_BITS-1:0] in_vel_x,
  input  logic signed [grk_pkg::WORD_BITS-1:0] in_vel_y,
  input  logic signed [grk_pkg::WORD_BITS-1:0] in_vel_z,
  input  logic [grk_pkg::MASS_BITS-1:0]    body_mass,
  input  logic                             last_body,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [grk_pkg::WORD_BITS-1:0] new_vel_x,
  output logic signed [grk_pkg::WORD_BITS-1:0] new_vel_y,
  output logic signed [grk_pkg::WORD_BITS-1:0] new_vel_z,
  output logic                             is_source,
  output logic                             end_of_pass,
  output logic                             saturated
);

  localparam int W = grk_pkg::WORD_BITS;
  localparam int F = grk_pkg::FRAC_BITS;

  grk_pkg::state_t state, state_next;
  logic       issued;
  logic [1:0] axis;
  logic       in_fire;
  logic       out_free;
  logic       unit_done;

  // Configuration and source state.
  logic [grk_pkg::COEF_BITS-1:0] gr_coef;
  logic [grk_pkg::TIME_BITS-1:0] kick_time;
  grk_pkg::word_t                src_pos [3];
  grk_pkg::word_t                src_vel [3];
  logic [grk_pkg::MASS_BITS-1:0] src_mass;
  logic                          src_sat;

  // Body transaction and working values.
  logic                          b_last;
  grk_pkg::word_t                b_pos [3];
  grk_pkg::word_t                b_vel [3];
  logic [grk_pkg::MASS_BITS-1:0] b_mass;
  logic [W-2:0]                  dm [3];
  logic                          dn [3];
  logic [grk_pkg::R2_BITS-1:0]   r2;
  grk_pkg::mag_t                 scratch;
  grk_pkg::prod_t                num;
  grk_pkg::prod_t                den;
  grk_pkg::mag_t                 prefac;
  grk_pkg::mag_t                 kick;
  grk_pkg::word_t                body_vel [3];
  logic                          body_sat;

  // Output register.
  grk_pkg::word_t out_vel [3];
  logic           out_src;
  logic           out_end;
  logic           out_sat;

  // Shared unit ports.
  logic           mul_start, mul_busy, mul_done;
  grk_pkg::mag_t  mul_a, mul_b;
  grk_pkg::prod_t mul_prod;
  logic           div_start, div_done;
  grk_pkg::prod_t div_num, div_den, div_quo;

  // Per-axis combinational results.
  grk_pkg::sm_t   diff [3];
  logic           diff_sat;
  logic           den_zero;
  logic           mass_zero;
  grk_pkg::mag_t  kick_val;
  logic           kick_sat;
  grk_pkg::sm_t   body_sum;
  grk_pkg::enc_t  body_enc;
  grk_pkg::mag_t  react_val;
  logic           react_sat;
  grk_pkg::sm_t   src_sum;
  grk_pkg::enc_t  src_enc;
  grk_pkg::sm_t   vel_dec;
  grk_pkg::sm_t   src_dec;

  grk_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .busy(mul_busy), .done(mul_done), .prod(mul_prod)
  );

  grk_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Separations on all three axes, saturation and sign-magnitude updates for the current axis.
  always_comb begin
    diff_sat = 1'b0;
    for (int k = 0; k < 3; k++) begin
      diff[k]  = grk_pkg::pos_diff(b_pos[k], src_pos[k]);
      diff_sat = diff_sat | diff[k].flag;
    end
    den_zero  = (den == '0);
    mass_zero = (src_mass == '0);
    kick_sat  = (mul_prod[grk_pkg::PROD_BITS-1:112] != '0);
    kick_val  = kick_sat ? {grk_pkg::MAG_BITS{1'b1}} : mul_prod[111:48];
    vel_dec   = grk_pkg::decode(b_vel[axis]);
    body_sum  = grk_pkg::sm_add(vel_dec.neg, vel_dec.mag, !dn[axis], kick_val);
    body_enc  = grk_pkg::encode(body_sum.neg, body_sum.mag);
    react_sat = !mass_zero && (div_quo[grk_pkg::PROD_BITS-1:grk_pkg::MAG_BITS] != '0);
    react_val = mass_zero ? '0 :
                (react_sat ? {grk_pkg::MAG_BITS{1'b1}} : div_quo[grk_pkg::MAG_BITS-1:0]);
    src_dec   = grk_pkg::decode(src_vel[axis]);
    src_sum   = grk_pkg::sm_add(src_dec.neg, src_dec.mag, dn[axis], react_val);
    src_enc   = grk_pkg::encode(src_sum.neg, src_sum.mag);
  end

  // Completion of the current operation.
  always_comb begin
    case (state)
      grk_pkg::S_R2, grk_pkg::S_COEF, grk_pkg::S_P1, grk_pkg::S_DEN, grk_pkg::S_PDT,
      grk_pkg::S_KICK, grk_pkg::S_RMUL: unit_done = mul_done;
      grk_pkg::S_PREFAC: unit_done = den_zero || div_done;
      grk_pkg::S_RDIV:   unit_done = mass_zero || div_done;
      default:           unit_done = 1'b0;
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      grk_pkg::S_IDLE: begin
        if (in_fire) begin
          if (command == grk_pkg::CMD_KICK) state_next = grk_pkg::S_DIFF;
          else if (last_body) state_next = grk_pkg::S_EMIT_SRC;
        end
      end
      grk_pkg::S_DIFF: state_next = grk_pkg::S_R2;
      grk_pkg::S_R2: begin
        if (unit_done && axis == 2'd2) state_next = grk_pkg::S_COEF;
      end
      grk_pkg::S_COEF:   if (unit_done) state_next = grk_pkg::S_P1;
      grk_pkg::S_P1:     if (unit_done) state_next = grk_pkg::S_DEN;
      grk_pkg::S_DEN:    if (unit_done) state_next = grk_pkg::S_PREFAC;
      grk_pkg::S_PREFAC: if (unit_done) state_next = grk_pkg::S_PDT;
      grk_pkg::S_PDT:    if (unit_done) state_next = grk_pkg::S_KICK;
      grk_pkg::S_KICK:   if (unit_done) state_next = grk_pkg::S_RMUL;
      grk_pkg::S_RMUL:   if (unit_done) state_next = grk_pkg::S_RDIV;
      grk_pkg::S_RDIV: begin
        if (unit_done) state_next = (axis == 2'd2) ? grk_pkg::S_EMIT_BODY : grk_pkg::S_KICK;
      end
      grk_pkg::S_EMIT_BODY: begin
        if (out_free) state_next = b_last ? grk_pkg::S_EMIT_SRC : grk_pkg::S_IDLE;
      end
      grk_pkg::S_EMIT_SRC: if (out_free) state_next = grk_pkg::S_IDLE;
      default: state_next = grk_pkg::S_IDLE;
    endcase
  end

  // Unit starts and operand selection.
  always_comb begin
    in_stall  = (state != grk_pkg::S_IDLE);
    mul_start = 1'b0;
    div_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_num   = num;
    div_den   = den;
    case (state)
      grk_pkg::S_R2: begin
        mul_start = !issued;
        mul_a     = grk_pkg::mag_t'(dm[axis]);
        mul_b     = grk_pkg::mag_t'(dm[axis]);
      end
      grk_pkg::S_COEF: begin
        mul_start = !issued;
        mul_a     = grk_pkg::mag_t'(gr_coef);
        mul_b     = grk_pkg::mag_t'(src_mass);
      end
      grk_pkg::S_P1: begin
        mul_start = !issued;
        mul_a     = scratch;
        mul_b     = grk_pkg::mag_t'(src_mass);
      end
      grk_pkg::S_DEN: begin
        mul_start = !issued;
        mul_a     = r2[grk_pkg::R2_BITS-1:F];
        mul_b     = r2[grk_pkg::R2_BITS-1:F];
      end
      grk_pkg::S_PREFAC: div_start = !issued && !den_zero;
      grk_pkg::S_PDT: begin
        mul_start = !issued;
        mul_a     = prefac;
        mul_b     = grk_pkg::mag_t'(kick_time);
      end
      grk_pkg::S_KICK: begin
        mul_start = !issued;
        mul_a     = scratch;
        mul_b     = grk_pkg::mag_t'(dm[axis]);
      end
      grk_pkg::S_RMUL: begin
        mul_start = !issued;
        mul_a     = kick;
        mul_b     = grk_pkg::mag_t'(b_mass);
      end
      grk_pkg::S_RDIV: begin
        div_start = !issued && !mass_zero;
        div_num   = mul_prod;
        div_den   = grk_pkg::prod_t'(src_mass);
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= grk_pkg::S_IDLE;
      issued <= 1'b0;
      axis   <= 2'd0;
    end else begin
      state <= state_next;
      if (mul_start || div_start) issued <= 1'b1;
      else if (unit_done) issued <= 1'b0;
      if (state == grk_pkg::S_DIFF) begin
        axis <= 2'd0;
      end else if (unit_done && (state == grk_pkg::S_R2 || state == grk_pkg::S_RDIV)) begin
        axis <= (axis == 2'd2) ? 2'd0 : axis + 2'd1;
      end
    end
  end

  // Configuration, source state and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      gr_coef   <= '0;
      kick_time <= '0;
      src_mass  <= '0;
      src_sat   <= 1'b0;
      out_valid <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        src_pos[k] <= '0;
        src_vel[k] <= '0;
      end
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          grk_pkg::REG_GR_COEF:   gr_coef   <= cfg_data;
          grk_pkg::REG_KICK_TIME: kick_time <= cfg_data[grk_pkg::TIME_BITS-1:0];
          default: gr_coef <= gr_coef;
        endcase
      end
      if (in_fire && command == grk_pkg::CMD_LOAD) begin
        src_pos[0] <= pos_x;
        src_pos[1] <= pos_y;
        src_pos[2] <= pos_z;
        src_vel[0] <= in_vel_x;
        src_vel[1] <= in_vel_y;
        src_vel[2] <= in_vel_z;
        src_mass   <= body_mass;
        src_sat    <= 1'b0;
      end
      if (state == grk_pkg::S_RDIV && unit_done) begin
        src_vel[axis] <= src_enc.value;
        src_sat       <= src_sat | react_sat | src_sum.flag | src_enc.flag;
      end
      if ((state == grk_pkg::S_EMIT_BODY || state == grk_pkg::S_EMIT_SRC) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working values of the body transaction and the output payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      b_last   <= last_body;
      b_pos[0] <= pos_x;
      b_pos[1] <= pos_y;
      b_pos[2] <= pos_z;
      b_vel[0] <= in_vel_x;
      b_vel[1] <= in_vel_y;
      b_vel[2] <= in_vel_z;
      b_mass   <= body_mass;
    end
    case (state)
      grk_pkg::S_DIFF: begin
        for (int k = 0; k < 3; k++) begin
          dm[k] <= diff[k].mag[W-2:0];
          dn[k] <= diff[k].neg;
        end
        body_sat <= diff_sat;
        r2       <= '0;
      end
      grk_pkg::S_R2:   if (unit_done) r2 <= r2 + mul_prod[grk_pkg::R2_BITS-1:0];
      grk_pkg::S_COEF: if (unit_done) scratch <= mul_prod[grk_pkg::MAG_BITS+F-1:F];
      grk_pkg::S_P1:   if (unit_done) num <= {mul_prod[95:16], 48'd0};
      grk_pkg::S_DEN:  if (unit_done) den <= mul_prod;
      grk_pkg::S_PREFAC: begin
        if (den_zero) begin
          prefac   <= {grk_pkg::MAG_BITS{1'b1}};
          body_sat <= 1'b1;
        end else if (div_done) begin
          if (div_quo[grk_pkg::PROD_BITS-1:grk_pkg::MAG_BITS] != '0) begin
            prefac   <= {grk_pkg::MAG_BITS{1'b1}};
            body_sat <= 1'b1;
          end else begin
            prefac <= div_quo[grk_pkg::MAG_BITS-1:0];
          end
        end
      end
      grk_pkg::S_PDT:  if (unit_done) scratch <= mul_prod[grk_pkg::MAG_BITS+F-1:F];
      grk_pkg::S_KICK: begin
        if (unit_done) begin
          kick           <= kick_val;
          body_vel[axis] <= body_enc.value;
          body_sat       <= body_sat | kick_sat | body_sum.flag | body_enc.flag;
        end
      end
      grk_pkg::S_EMIT_BODY: begin
        if (out_free) begin
          for (int k = 0; k < 3; k++) out_vel[k] <= body_vel[k];
          out_src <= 1'b0;
          out_end <= 1'b0;
          out_sat <= body_sat;
        end
      end
      grk_pkg::S_EMIT_SRC: begin
        if (out_free) begin
          for (int k = 0; k < 3; k++) out_vel[k] <= src_vel[k];
          out_src <= 1'b1;
          out_end <= 1'b1;
          out_sat <= src_sat;
        end
      end
      default: begin
        kick <= kick;
      end
    endcase
  end

  assign new_vel_x   = out_vel[0];
  assign new_vel_y   = out_vel[1];
  assign new_vel_z   = out_vel[2];
  assign is_source   = out_src;
  assign end_of_pass = out_end;
  assign saturated   = out_sat;

`ifndef SYNTHESIS
  // The two shared units are never started together.
  a_one_start: assert property (@(posedge clk) disable iff (rst)
    !(mul_start && div_start))
    else $error("multiplier and divider started in the same cycle");

  // The multiplier is only started when it is free.
  a_mul_free: assert property (@(posedge clk) disable iff (rst)
    mul_start |-> !mul_busy)
    else $error("multiplier started while busy");

  // The axis counter stays within the three axes.
  a_axis_range: assert property (@(posedge clk) disable iff (rst)
    axis != 2'd3)
    else $error("axis counter out of range");

  // A source result is always the end of its pass.
  a_src_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_source |-> end_of_pass)
    else $error("source result without end of pass");
`endif

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for gr_potential_velocity_kick_top: directed passes, then random
// passes under four handshake pressure phases, all checked against an in-bench predictor.
// Depends on grk_pkg and the RTL under hdl.
`default_nettype none

module tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 6000000;

  // One body transaction as the sender presents it.
  typedef struct packed {
    logic                          cmd;
    grk_pkg::word_t [2:0]          pos;
    grk_pkg::word_t [2:0]          vel;
    logic [grk_pkg::MASS_BITS-1:0] mass;
    logic                          last;
  } body_t;

  // One velocity result as the block returns it.
  typedef struct packed {
    grk_pkg::word_t [2:0] vel;
    logic                 src;
    logic                 eop;
    logic                 sat;
  } vel_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic cfg_index = grk_pkg::REG_GR_COEF;
  logic [grk_pkg::COEF_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic command = grk_pkg::CMD_LOAD;
  logic signed [grk_pkg::WORD_BITS-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic signed [grk_pkg::WORD_BITS-1:0] in_vel_x = '0, in_vel_y = '0, in_vel_z = '0;
  logic [grk_pkg::MASS_BITS-1:0] body_mass = '0;
  logic last_body = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [grk_pkg::WORD_BITS-1:0] new_vel_x, new_vel_y, new_vel_z;
  logic is_source, end_of_pass, saturated;

  // Predictor copy of configuration and source state.
  logic [grk_pkg::COEF_BITS-1:0] coef_q;
  logic [grk_pkg::TIME_BITS-1:0] ktime_q;
  grk_pkg::word_t [2:0]          src_pos_q;
  grk_pkg::word_t [2:0]          src_vel_q;
  logic [grk_pkg::MASS_BITS-1:0] src_mass_q;
  logic                          src_sat_q;

  vel_result_t expected_vel_q[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  gr_potential_velocity_kick_top i_dut (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .command, .pos_x, .pos_y, .pos_z,
    .in_vel_x, .in_vel_y, .in_vel_z, .body_mass, .last_body,
    .out_valid, .out_stall, .new_vel_x, .new_vel_y, .new_vel_z,
    .is_source, .end_of_pass, .saturated
  );

  always #6 clk = ~clk;

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Fixed-point helpers of the predictor.
  function automatic grk_pkg::mag_t sat_mag(input grk_pkg::prod_t a, inout logic f);
    if (a[grk_pkg::PROD_BITS-1:grk_pkg::MAG_BITS] != '0) begin
      f = 1'b1;
      return '1;
    end
    return a[grk_pkg::MAG_BITS-1:0];
  endfunction

  function automatic grk_pkg::mag_t mag_of(input grk_pkg::word_t v, output logic n);
    grk_pkg::word_t t;
    n = v[grk_pkg::WORD_BITS-1];
    t = n ? (~v + 1'b1) : v;
    return grk_pkg::mag_t'(t);
  endfunction

  function automatic grk_pkg::mag_t clamp_mag(input logic n, input grk_pkg::mag_t m,
                                              inout logic f);
    grk_pkg::mag_t lim;
    lim = n ? (grk_pkg::mag_t'(1) << (grk_pkg::WORD_BITS-1))
            : ((grk_pkg::mag_t'(1) << (grk_pkg::WORD_BITS-1)) - 1'b1);
    if (m > lim) begin
      f = 1'b1;
      return lim;
    end
    return m;
  endfunction

  function automatic grk_pkg::mag_t signed_sum(input logic an, input grk_pkg::mag_t am,
                                               input logic bn, input grk_pkg::mag_t bm,
                                               output logic rn, inout logic f);
    logic [grk_pkg::MAG_BITS:0] s;
    s = {1'b0, am} + {1'b0, bm};
    if (an == bn) begin
      rn = an;
      if (s[grk_pkg::MAG_BITS]) begin
        f = 1'b1;
        return '1;
      end
      return s[grk_pkg::MAG_BITS-1:0];
    end
    if (am >= bm) begin
      rn = an;
      return am - bm;
    end
    rn = bn;
    return bm - am;
  endfunction

  function automatic grk_pkg::word_t to_word(input logic n, input grk_pkg::mag_t m,
                                             inout logic f);
    grk_pkg::mag_t  c;
    grk_pkg::word_t t;
    c = clamp_mag(n, m, f);
    t = c[grk_pkg::WORD_BITS-1:0];
    return n ? (~t + 1'b1) : t;
  endfunction

  // Expected velocity results of one accepted body transaction.
  task automatic predict_velocities(input body_t b);
    grk_pkg::mag_t  dm[3];
    logic           dn[3];
    logic           f, sf, pn, sn, vn, rn;
    grk_pkg::mag_t  pm, sm, r2q, a, prefac, pdt, kick, react, vm, nm;
    grk_pkg::prod_t r2, t, p1, num, den;
    vel_result_t    res;
    f  = 1'b0;
    sf = 1'b0;
    if (b.cmd == grk_pkg::CMD_LOAD) begin
      src_pos_q  = b.pos;
      src_vel_q  = b.vel;
      src_mass_q = b.mass;
      src_sat_q  = 1'b0;
    end else begin
      // Separation and squared distance.
      r2 = '0;
      for (int k = 0; k < 3; k++) begin
        pm = mag_of(b.pos[k], pn);
        sm = mag_of(src_pos_q[k], sn);
        dm[k] = clamp_mag(1'b0, signed_sum(pn, pm, !sn, sm, dn[k], f), f);
        r2 = r2 + grk_pkg::prod_t'(dm[k]) * grk_pkg::prod_t'(dm[k]);
      end
      r2q = sat_mag(r2 >> grk_pkg::FRAC_BITS, f);
      // Prefactor coef*m0^2/r^4 and its product with the kick time.
      t   = (grk_pkg::prod_t'(coef_q) * grk_pkg::prod_t'(src_mass_q)) >> 32;
      a   = t[grk_pkg::MAG_BITS-1:0];
      p1  = (grk_pkg::prod_t'(a) * grk_pkg::prod_t'(src_mass_q)) >> 16;
      num = p1 << 48;
      den = grk_pkg::prod_t'(r2q) * grk_pkg::prod_t'(r2q);
      if (den == '0) begin
        prefac = '1;
        f = 1'b1;
      end else begin
        prefac = sat_mag(num / den, f);
      end
      t   = (grk_pkg::prod_t'(prefac) * grk_pkg::prod_t'(ktime_q)) >> 32;
      pdt = t[grk_pkg::MAG_BITS-1:0];
      // Body kick and the mass-weighted reaction on the source.
      for (int k = 0; k < 3; k++) begin
        kick = sat_mag((grk_pkg::prod_t'(pdt) * grk_pkg::prod_t'(dm[k])) >> 48, f);
        vm = mag_of(b.vel[k], vn);
        nm = signed_sum(vn, vm, !dn[k], kick, rn, f);
        res.vel[k] = to_word(rn, nm, f);
        react = '0;
        if (src_mass_q != '0)
          react = sat_mag((grk_pkg::prod_t'(kick) * grk_pkg::prod_t'(b.mass))
                          / grk_pkg::prod_t'(src_mass_q), sf);
        vm = mag_of(src_vel_q[k], vn);
        nm = signed_sum(vn, vm, dn[k], react, rn, sf);
        src_vel_q[k] = to_word(rn, nm, sf);
      end
      if (sf) src_sat_q = 1'b1;
      res.src = 1'b0;
      res.eop = 1'b0;
      res.sat = f;
      expected_vel_q.push_back(res);
    end
    if (b.last) begin
      res.vel = src_vel_q;
      res.src = 1'b1;
      res.eop = 1'b1;
      res.sat = src_sat_q;
      expected_vel_q.push_back(res);
    end
  endtask

  // Result checker: each accepted result against the oldest expectation.
  always @(posedge clk) begin
    vel_result_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got.vel = {new_vel_z, new_vel_y, new_vel_x};
      got.src = is_source;
      got.eop = end_of_pass;
      got.sat = saturated;
      if (expected_vel_q.size() == 0) begin
        $display("%0t unexpected result: actual %h", $time, got);
        error_count <= error_count + 1;
      end else begin
        want = expected_vel_q.pop_front();
        if (got !== want) begin
          $display("%0t mismatch: expected vel %h %h %h src %b eop %b sat %b", $time,
                   want.vel[0], want.vel[1], want.vel[2], want.src, want.eop, want.sat);
          $display("%0t          actual   vel %h %h %h src %b eop %b sat %b", $time,
                   got.vel[0], got.vel[1], got.vel[2], got.src, got.eop, got.sat);
          error_count <= error_count + 1;
        end
      end
    end
  end

  // Send one body; called just after a rising edge, returns at its acceptance edge.
  task automatic send_body(input body_t b);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(0, 99) < sender_idle_pct && gap < 40) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    command   <= b.cmd;
    pos_x     <= b.pos[0];
    pos_y     <= b.pos[1];
    pos_z     <= b.pos[2];
    in_vel_x  <= b.vel[0];
    in_vel_y  <= b.vel[1];
    in_vel_z  <= b.vel[2];
    body_mass <= b.mass;
    last_body <= b.last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_velocities(b);
  endtask

  // Wait for every expected result, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_vel_q.size() != 0) @(posedge clk);
    repeat (700) @(posedge clk);
  endtask

  // Register write while the block is idle.
  task automatic write_reg(input logic idx, input logic [grk_pkg::COEF_BITS-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == grk_pkg::REG_GR_COEF) coef_q = value;
    else ktime_q = value[grk_pkg::TIME_BITS-1:0];
  endtask

  function automatic grk_pkg::word_t rand_word();
    logic [63:0] r;
    grk_pkg::word_t w;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 15))
      0: w = {1'b1, {(grk_pkg::WORD_BITS-1){1'b0}}};
      1: w = {1'b0, {(grk_pkg::WORD_BITS-1){1'b1}}};
      default: begin
        w = r[grk_pkg::WORD_BITS-1:0] >> $urandom_range(0, grk_pkg::WORD_BITS-1);
        if (r[63]) w = ~w + 1'b1;
      end
    endcase
    return w;
  endfunction

  function automatic logic [grk_pkg::MASS_BITS-1:0] rand_mass();
    logic [63:0] r;
    r = {$urandom, $urandom};
    if ($urandom_range(0, 15) == 0) return '1;
    return r[grk_pkg::MASS_BITS-1:0] >> $urandom_range(0, grk_pkg::MASS_BITS-1);
  endfunction

  function automatic body_t rand_body(input logic cmd, input logic last);
    body_t b;
    b.cmd  = cmd;
    b.last = last;
    for (int k = 0; k < 3; k++) begin
      b.pos[k] = rand_word();
      b.vel[k] = rand_word();
    end
    b.mass = rand_mass();
    return b;
  endfunction

  function automatic body_t make_body(input logic cmd, input grk_pkg::word_t p,
                                      input grk_pkg::word_t v,
                                      input logic [grk_pkg::MASS_BITS-1:0] m,
                                      input logic last);
    body_t b;
    b.cmd  = cmd;
    b.pos  = {p, p, p};
    b.vel  = {v, v, v};
    b.mass = m;
    b.last = last;
    return b;
  endfunction

  // Directed special cases and field extremes.
  task automatic test_directed();
    grk_pkg::word_t maxw, minw, one;
    body_t b;
    maxw = {1'b0, {(grk_pkg::WORD_BITS-1){1'b1}}};
    minw = {1'b1, {(grk_pkg::WORD_BITS-1){1'b0}}};
    one  = grk_pkg::word_t'(1) << grk_pkg::FRAC_BITS;
    // Kick before any load, then with a small coefficient and a kick time of one half.
    send_body(make_body(grk_pkg::CMD_KICK, one, one, '1, 1'b1));
    drain();
    write_reg(grk_pkg::REG_GR_COEF, 48'h0000_0010_0000);
    write_reg(grk_pkg::REG_KICK_TIME, 48'h0000_8000_0000);
    send_body(make_body(grk_pkg::CMD_LOAD, '0, '0, '0, 1'b1));
    send_body(make_body(grk_pkg::CMD_KICK, one, one, one, 1'b1));
    send_body(make_body(grk_pkg::CMD_LOAD, '0, '0, 40'h01_0000_0000, 1'b0));
    send_body(make_body(grk_pkg::CMD_KICK, one, maxw, 40'h01_0000_0000, 1'b0));
    // Zero separation, a unit separation on one axis, then separation overflow.
    send_body(make_body(grk_pkg::CMD_KICK, '0, minw, '1, 1'b0));
    b = make_body(grk_pkg::CMD_KICK, '0, '0, one, 1'b0);
    b.pos[1] = one;
    send_body(b);
    send_body(make_body(grk_pkg::CMD_LOAD, maxw, maxw, '1, 1'b0));
    send_body(make_body(grk_pkg::CMD_KICK, minw, minw, '1, 1'b1));
    drain();
    // Extreme constants with close and tiny bodies.
    write_reg(grk_pkg::REG_GR_COEF, '1);
    write_reg(grk_pkg::REG_KICK_TIME, 48'h0000_ffff_ffff);
    send_body(make_body(grk_pkg::CMD_LOAD, '0, minw, '1, 1'b0));
    send_body(make_body(grk_pkg::CMD_KICK, grk_pkg::word_t'(1), maxw, '1, 1'b0));
    send_body(make_body(grk_pkg::CMD_KICK, grk_pkg::word_t'(48'h1_0000), '0, '1, 1'b0));
    send_body(make_body(grk_pkg::CMD_KICK, minw, '1, '0, 1'b1));
    send_body(make_body(grk_pkg::CMD_LOAD, one, one, '1, 1'b1));
    send_body(make_body(grk_pkg::CMD_KICK, '1, maxw, 40'h1, 1'b1));
    drain();
  endtask

  // Random passes: a load followed by kicks, with some noise between passes.
  task automatic test_random(input int unsigned items);
    int unsigned sent, nkick;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(0, 9) == 0) begin
        send_body(rand_body(logic'($urandom_range(0, 1)), logic'($urandom_range(0, 1))));
        sent++;
      end else if ($urandom_range(0, 7) == 0) begin
        send_body(rand_body(grk_pkg::CMD_LOAD, 1'b1));
        sent++;
      end else begin
        send_body(rand_body(grk_pkg::CMD_LOAD, 1'b0));
        nkick = $urandom_range(1, 6);
        for (int i = 1; i <= nkick; i++) send_body(rand_body(grk_pkg::CMD_KICK, i == nkick));
        sent += nkick + 1;
      end
    end
    drain();
  endtask

  // Pressure phases, each with its own register setting.
  task automatic test_pressure_phases();
    int unsigned idle_tab[4];
    int unsigned stall_tab[4];
    logic [63:0] r;
    idle_tab  = '{0, 75, 0, 34};
    stall_tab = '{0, 0, 75, 34};
    for (int p = 0; p < 4; p++) begin
      r = {$urandom, $urandom};
      write_reg(grk_pkg::REG_GR_COEF, r[grk_pkg::COEF_BITS-1:0] >> $urandom_range(0, 20));
      write_reg(grk_pkg::REG_KICK_TIME, 48'($urandom) >> $urandom_range(0, 8));
      sender_idle_pct = idle_tab[p];
      recv_stall_pct  = stall_tab[p];
      test_random(380);
    end
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    write_reg(grk_pkg::REG_GR_COEF, '0);
    write_reg(grk_pkg::REG_KICK_TIME, '0);
    test_random(30);
  endtask

  initial begin
    coef_q     = '0;
    ktime_q    = '0;
    src_pos_q  = '0;
    src_vel_q  = '0;
    src_mass_q = '0;
    src_sat_q  = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_pressure_phases();
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
hdl/grk_pkg.sv
hdl/grk_mul.sv
hdl/grk_div.sv
hdl/gr_potential_velocity_kick_top.sv
verif/tb.sv
